### design/tpoc_pkg.sv
// Shared types, widths and constants of the time-proportional output controller.
package tpoc_pkg;

    localparam int NUM_CHANNELS = 8;

    localparam int CH_W      = 3;
    localparam int CNT_W     = 4;
    localparam int MEM_DEPTH = 2 ** CH_W;
    localparam int TENTHS_W  = 10;
    localparam int TIME_W    = 32;
    localparam int CYC_W     = 14;
    localparam int PROD_W    = 24;
    localparam int MODE_W    = 2;
    localparam int MASK_W    = 8;
    localparam int REG_IDX_W = 3;
    localparam int CFG_W     = 32;

    localparam logic [CYC_W-1:0]    CYCLE_MIN   = 14'd200;
    localparam logic [CYC_W-1:0]    CYCLE_MAX   = 14'd10000;
    localparam logic [CYC_W-1:0]    CYCLE_RESET = 14'd1000;
    localparam logic [TIME_W-1:0]   TIMEOUT_RESET = 32'd5000;
    localparam logic [TENTHS_W-1:0] FULL_TENTHS = 10'd1000;
    localparam logic [TENTHS_W-1:0] HALF_TENTHS = 10'd500;

    localparam logic [MODE_W-1:0] MODE_ON_OFF    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TIME_PROP = 2'd2;

    localparam logic KIND_TICK    = 1'b0;
    localparam logic KIND_COMMAND = 1'b1;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_CYCLE_MS         = 3'd0,
        REG_TIMEOUT_MS       = 3'd1,
        REG_ENABLE_MASK      = 3'd2,
        REG_CRITICAL_MASK    = 3'd3,
        REG_CHANNEL_MODES    = 3'd4,
        REG_ACTIVE_HIGH_MASK = 3'd5,
        REG_CRITICAL_ALLOWED = 3'd6
    } reg_index_t;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_CMD_WR = 5'b00010,
        S_EVAL   = 5'b00100,
        S_MUL    = 5'b01000,
        S_FIN    = 5'b10000
    } seq_state_t;

    typedef struct packed {
        logic [TENTHS_W-1:0] tenths;
        logic [TIME_W-1:0]   cmd_time;
        logic                seen;
        logic [TIME_W-1:0]   window_start;
    } chan_entry_t;

    typedef struct packed {
        logic            en;
        logic [CH_W-1:0] addr;
    } store_rd_t;

    typedef struct packed {
        logic            en;
        logic [CH_W-1:0] addr;
        chan_entry_t     data;
    } store_wr_t;

endpackage

### design/tpoc_chan_store.sv
// Per-channel state memory with registered read and reset-cleared entry valid bits.
module tpoc_chan_store (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tpoc_pkg::store_rd_t  rd,
    input  tpoc_pkg::store_wr_t  wr,
    output tpoc_pkg::chan_entry_t rd_data
);

    tpoc_pkg::chan_entry_t mem [tpoc_pkg::MEM_DEPTH];
    logic [tpoc_pkg::MEM_DEPTH-1:0] valid_reg;
    tpoc_pkg::chan_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd.en)
        begin
            rd_data_reg <= valid_reg[rd.addr] ? mem[rd.addr] : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr.en)
        begin
            valid_reg[wr.addr] <= 1'b1;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### design/time_proportional_output_controller_core.sv
// Top level of the time-proportional output controller: handshakes, sequencer and datapath.
//
// The item channel (item_valid, item_stall) takes two kinds of item. A command item for
// an enabled channel sets its power and stamps its time; it gives no result. A tick item
// walks every channel through the state memory and gives one result per channel, in
// channel order, with last set on the final channel. For each channel, memory read data
// is evaluated and written back, the window products are formed, and the result is
// compared and loaded. The block takes one item at a time; item_stall is low only
// while the sequencer idles. Results leave through an output register (result_valid,
// result_stall). When the receiver stalls, the sequencer waits at the load of the next
// result, so nothing is lost; the next item is accepted while the final result of a
// tick still waits. The configuration channel (cfg_valid, cfg_ready, cfg_index,
// cfg_data) is always ready; the user must write it only while the block is idle, as
// the block itself does not enforce this. Reset restores the register defaults, clears
// the safety lock and marks every channel entry as zero; no clearing pass is needed.
module time_proportional_output_controller_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  logic                                kind,
    input  logic [tpoc_pkg::TIME_W-1:0]         now_ms,
    input  logic [tpoc_pkg::CH_W-1:0]           channel,
    input  logic [tpoc_pkg::TENTHS_W-1:0]       percent_tenths,
    input  logic                                safety_tripped,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic [tpoc_pkg::CH_W-1:0]           out_channel,
    output logic                                output_on,
    output logic                                pin_level,
    output logic [tpoc_pkg::TENTHS_W-1:0]       applied_tenths,
    output logic                                last,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tpoc_pkg::REG_IDX_W-1:0]      cfg_index,
    input  logic [tpoc_pkg::CFG_W-1:0]          cfg_data
);

    tpoc_pkg::seq_state_t state_reg, state_next;

    logic [tpoc_pkg::CYC_W-1:0]    cycle_ms_reg;
    logic [tpoc_pkg::TIME_W-1:0]   timeout_reg;
    logic [tpoc_pkg::MASK_W-1:0]   enable_mask_reg;
    logic [tpoc_pkg::MASK_W-1:0]   critical_mask_reg;
    logic [2*tpoc_pkg::MASK_W-1:0] modes_reg;
    logic [tpoc_pkg::MASK_W-1:0]   active_high_reg;
    logic                          crit_allowed_reg;
    logic                          lock_reg;

    logic [tpoc_pkg::TIME_W-1:0]   now_reg;
    logic [tpoc_pkg::CH_W-1:0]     chan_reg;
    logic [tpoc_pkg::TENTHS_W-1:0] cmd_tenths_reg;
    logic [tpoc_pkg::TENTHS_W-1:0] applied_reg;
    logic [tpoc_pkg::CYC_W-1:0]    elapsed_reg;
    logic [tpoc_pkg::MODE_W-1:0]   mode_reg;
    logic [tpoc_pkg::PROD_W-1:0]   prod_reg;
    logic [tpoc_pkg::PROD_W-1:0]   thr_reg;

    logic                          out_valid_reg;
    logic [tpoc_pkg::CH_W-1:0]     out_channel_reg;
    logic                          out_on_reg;
    logic                          out_pin_reg;
    logic [tpoc_pkg::TENTHS_W-1:0] out_tenths_reg;
    logic                          out_last_reg;

    tpoc_pkg::store_rd_t   rd;
    tpoc_pkg::store_wr_t   wr;
    tpoc_pkg::chan_entry_t rd_data;

    logic                          item_accept;
    logic                          cmd_ok;
    logic                          crit_ok_now;
    logic [tpoc_pkg::TENTHS_W-1:0] pct_sat;
    logic [tpoc_pkg::TENTHS_W-1:0] pct_store;
    logic [tpoc_pkg::CYC_W-1:0]    cyc_clamp;

    logic                          crit_ok;
    logic [tpoc_pkg::TIME_W-1:0]   time_diff;
    logic [tpoc_pkg::TIME_W-1:0]   wdiff;
    logic                          timed_out;
    logic                          kill;
    logic [tpoc_pkg::TENTHS_W-1:0] new_tenths;
    logic [tpoc_pkg::MODE_W-1:0]   mode_cur;
    logic                          restart;
    logic [tpoc_pkg::TIME_W-1:0]   ws_new;
    logic [tpoc_pkg::CYC_W-1:0]    elapsed_cur;

    logic                          chan_last;
    logic                          load_ok;
    logic                          load;
    logic                          on_cur;

    tpoc_chan_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd      (rd),
        .wr      (wr),
        .rd_data (rd_data)
    );

    assign item_stall  = (state_reg != tpoc_pkg::S_IDLE);
    assign item_accept = item_valid && !item_stall;
    assign cfg_ready   = 1'b1;

    assign crit_ok_now = crit_allowed_reg && !lock_reg;
    assign cmd_ok      = (tpoc_pkg::CNT_W'(channel) < tpoc_pkg::CNT_W'(tpoc_pkg::NUM_CHANNELS))
                         && enable_mask_reg[channel];
    assign pct_sat     = (percent_tenths > tpoc_pkg::FULL_TENTHS) ?
                         tpoc_pkg::FULL_TENTHS : percent_tenths;
    assign pct_store   = (critical_mask_reg[channel] && !crit_ok_now) ? '0 : pct_sat;

    always_comb
    begin
        cyc_clamp = cycle_ms_reg;
        if (cycle_ms_reg < tpoc_pkg::CYCLE_MIN)
        begin
            cyc_clamp = tpoc_pkg::CYCLE_MIN;
        end
        else if (cycle_ms_reg > tpoc_pkg::CYCLE_MAX)
        begin
            cyc_clamp = tpoc_pkg::CYCLE_MAX;
        end
    end

    assign crit_ok     = crit_allowed_reg && !lock_reg;
    assign time_diff   = now_reg - rd_data.cmd_time;
    assign timed_out   = (rd_data.tenths != '0) && rd_data.seen &&
                         (now_reg >= rd_data.cmd_time) && (time_diff > timeout_reg);
    assign kill        = !enable_mask_reg[chan_reg] || timed_out ||
                         (critical_mask_reg[chan_reg] && !crit_ok) || lock_reg;
    assign new_tenths  = kill ? '0 : rd_data.tenths;
    assign mode_cur    = modes_reg[{chan_reg, 1'b0} +: tpoc_pkg::MODE_W];
    assign wdiff       = now_reg - rd_data.window_start;
    assign restart     = (new_tenths != '0) && (mode_cur == tpoc_pkg::MODE_TIME_PROP) &&
                         (wdiff >= tpoc_pkg::TIME_W'(cyc_clamp));
    assign ws_new      = restart ? now_reg : rd_data.window_start;
    assign elapsed_cur = restart ? '0 : wdiff[tpoc_pkg::CYC_W-1:0];

    assign chan_last   = (chan_reg == tpoc_pkg::CH_W'(tpoc_pkg::NUM_CHANNELS - 1));
    assign load_ok     = !out_valid_reg || !result_stall;
    assign load        = (state_reg == tpoc_pkg::S_FIN) && load_ok;

    always_comb
    begin
        on_cur = 1'b0;
        if (applied_reg != '0)
        begin
            unique case (mode_reg)
                tpoc_pkg::MODE_ON_OFF:    on_cur = (applied_reg >= tpoc_pkg::HALF_TENTHS);
                tpoc_pkg::MODE_TIME_PROP: on_cur = (applied_reg >= tpoc_pkg::FULL_TENTHS) ||
                                                   (thr_reg <= prod_reg);
                default:                  on_cur = 1'b0;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        rd         = '0;
        wr         = '0;
        unique case (state_reg)
            tpoc_pkg::S_IDLE:
            begin
                if (item_accept)
                begin
                    if (kind == tpoc_pkg::KIND_TICK)
                    begin
                        rd.en      = 1'b1;
                        rd.addr    = '0;
                        state_next = tpoc_pkg::S_EVAL;
                    end
                    else if (cmd_ok)
                    begin
                        rd.en      = 1'b1;
                        rd.addr    = channel;
                        state_next = tpoc_pkg::S_CMD_WR;
                    end
                end
            end
            tpoc_pkg::S_CMD_WR:
            begin
                wr.en                = 1'b1;
                wr.addr              = chan_reg;
                wr.data.tenths       = cmd_tenths_reg;
                wr.data.cmd_time     = now_reg;
                wr.data.seen         = 1'b1;
                wr.data.window_start = rd_data.window_start;
                state_next           = tpoc_pkg::S_IDLE;
            end
            tpoc_pkg::S_EVAL:
            begin
                wr.en                = 1'b1;
                wr.addr              = chan_reg;
                wr.data.tenths       = new_tenths;
                wr.data.cmd_time     = rd_data.cmd_time;
                wr.data.seen         = rd_data.seen;
                wr.data.window_start = ws_new;
                state_next           = tpoc_pkg::S_MUL;
            end
            tpoc_pkg::S_MUL:
            begin
                state_next = tpoc_pkg::S_FIN;
            end
            tpoc_pkg::S_FIN:
            begin
                if (load_ok)
                begin
                    if (chan_last)
                    begin
                        state_next = tpoc_pkg::S_IDLE;
                    end
                    else
                    begin
                        rd.en      = 1'b1;
                        rd.addr    = chan_reg + 1'b1;
                        state_next = tpoc_pkg::S_EVAL;
                    end
                end
            end
            default:
            begin
                state_next = tpoc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= tpoc_pkg::S_IDLE;
            cycle_ms_reg      <= tpoc_pkg::CYCLE_RESET;
            timeout_reg       <= tpoc_pkg::TIMEOUT_RESET;
            enable_mask_reg   <= '0;
            critical_mask_reg <= '0;
            modes_reg         <= '0;
            active_high_reg   <= '1;
            crit_allowed_reg  <= 1'b0;
            lock_reg          <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (tpoc_pkg::reg_index_t'(cfg_index))
                    tpoc_pkg::REG_CYCLE_MS:
                        cycle_ms_reg <= cfg_data[tpoc_pkg::CYC_W-1:0];
                    tpoc_pkg::REG_TIMEOUT_MS:
                        timeout_reg <= cfg_data[tpoc_pkg::TIME_W-1:0];
                    tpoc_pkg::REG_ENABLE_MASK:
                        enable_mask_reg <= cfg_data[tpoc_pkg::MASK_W-1:0];
                    tpoc_pkg::REG_CRITICAL_MASK:
                        critical_mask_reg <= cfg_data[tpoc_pkg::MASK_W-1:0];
                    tpoc_pkg::REG_CHANNEL_MODES:
                        modes_reg <= cfg_data[2*tpoc_pkg::MASK_W-1:0];
                    tpoc_pkg::REG_ACTIVE_HIGH_MASK:
                        active_high_reg <= cfg_data[tpoc_pkg::MASK_W-1:0];
                    tpoc_pkg::REG_CRITICAL_ALLOWED:
                        crit_allowed_reg <= cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end
            if (item_accept && (kind == tpoc_pkg::KIND_TICK))
            begin
                lock_reg <= safety_tripped;
            end
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_accept)
        begin
            now_reg        <= now_ms;
            cmd_tenths_reg <= pct_store;
            chan_reg       <= (kind == tpoc_pkg::KIND_TICK) ? '0 : channel;
        end
        else if (load && !chan_last)
        begin
            chan_reg <= chan_reg + 1'b1;
        end
        if (state_reg == tpoc_pkg::S_EVAL)
        begin
            applied_reg <= new_tenths;
            elapsed_reg <= elapsed_cur;
            mode_reg    <= mode_cur;
        end
        if (state_reg == tpoc_pkg::S_MUL)
        begin
            prod_reg <= tpoc_pkg::PROD_W'(cyc_clamp) * tpoc_pkg::PROD_W'(applied_reg);
            thr_reg  <= tpoc_pkg::PROD_W'(tpoc_pkg::CYC_W'(elapsed_reg + 1'b1)) *
                        tpoc_pkg::PROD_W'(tpoc_pkg::FULL_TENTHS);
        end
        if (load)
        begin
            out_channel_reg <= chan_reg;
            out_on_reg      <= on_cur;
            out_pin_reg     <= ~(on_cur ^ active_high_reg[chan_reg]);
            out_tenths_reg  <= applied_reg;
            out_last_reg    <= chan_last;
        end
    end

    assign result_valid   = out_valid_reg;
    assign out_channel    = out_channel_reg;
    assign output_on      = out_on_reg;
    assign pin_level      = out_pin_reg;
    assign applied_tenths = out_tenths_reg;
    assign last           = out_last_reg;

    a_no_same_entry_rw: assert property (@(posedge clk) disable iff (!rst_n)
        (wr.en && rd.en) |-> (wr.addr != rd.addr))
        else $error("State memory read and write hit the same entry in one cycle.");

    a_applied_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tpoc_pkg::S_MUL) |-> (applied_reg <= tpoc_pkg::FULL_TENTHS))
        else $error("Applied power exceeds full scale.");

    a_lock_forces_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tpoc_pkg::S_FIN && lock_reg) |-> (applied_reg == '0))
        else $error("A channel carries power while the safety lock is set.");

    a_last_ends_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (load && chan_last) |=> (state_reg == tpoc_pkg::S_IDLE && out_last_reg))
        else $error("The sequencer did not return to idle after the final channel.");

endmodule

### tb/time_proportional_output_controller_core_tb.sv
// Self-checking testbench for the time-proportional output controller core.
`timescale 1ns / 100ps

module time_proportional_output_controller_core_tb;

    import tpoc_pkg::*;

    localparam int IDLE_PERCENT   = 28;
    localparam int SETTLE_CYCLES  = 40;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 100;

    localparam logic [MODE_W-1:0] MODE_OFF   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    typedef struct packed {
        logic                kind;
        logic [TIME_W-1:0]   now;
        logic [CH_W-1:0]     ch;
        logic [TENTHS_W-1:0] pct;
        logic                trip;
    } ctrl_item_t;

    typedef struct packed {
        logic [CH_W-1:0]     ch;
        logic                lit;
        logic                pin;
        logic [TENTHS_W-1:0] applied;
        logic                last;
    } chan_result_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                item_valid = 1'b0;
    logic                item_stall;
    logic                kind = KIND_TICK;
    logic [TIME_W-1:0]   now_ms = '0;
    logic [CH_W-1:0]     channel = '0;
    logic [TENTHS_W-1:0] percent_tenths = '0;
    logic                safety_tripped = 1'b0;
    logic                result_valid;
    logic                result_stall = 1'b0;
    logic [CH_W-1:0]     out_channel;
    logic                output_on;
    logic                pin_level;
    logic [TENTHS_W-1:0] applied_tenths;
    logic                last;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    reg_index_t          cfg_index = REG_CYCLE_MS;
    logic [CFG_W-1:0]    cfg_data = '0;

    logic [CYC_W-1:0]    window_len_cfg = CYCLE_RESET;
    logic [TIME_W-1:0]   timeout_cfg = TIMEOUT_RESET;
    logic [MASK_W-1:0]   enable_cfg = '0;
    logic [MASK_W-1:0]   critical_cfg = '0;
    logic [2*MASK_W-1:0] modes_cfg = '0;
    logic [MASK_W-1:0]   polarity_cfg = '1;
    logic                critical_ok_cfg = 1'b0;

    logic [TENTHS_W-1:0] power_cmd [NUM_CHANNELS];
    logic [TIME_W-1:0]   stamp_ms [NUM_CHANNELS];
    logic                has_cmd [NUM_CHANNELS];
    logic [TIME_W-1:0]   window_ms [NUM_CHANNELS];
    logic                locked = 1'b0;

    chan_result_t        expected_channel_results [$];
    int unsigned         errors = 0;
    logic [TIME_W-1:0]   sim_ms = '0;
    bit                  steady = 1'b0;
    int                  hold_request = 0;
    int                  hold_left = 0;

    time_proportional_output_controller_core u_top (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(string field, int unsigned got, int unsigned want,
                                   int unsigned ch);
        if (errors < MAX_REPORTS)
        begin
            $display("%0t: channel %0d %s: got %0d, want %0d", $time, ch, field, got, want);
        end
        errors++;
    endtask

    function automatic void apply_register(reg_index_t idx, logic [CFG_W-1:0] data);
        case (idx)
            REG_CYCLE_MS:         window_len_cfg = data[CYC_W-1:0];
            REG_TIMEOUT_MS:       timeout_cfg = data[TIME_W-1:0];
            REG_ENABLE_MASK:      enable_cfg = data[MASK_W-1:0];
            REG_CRITICAL_MASK:    critical_cfg = data[MASK_W-1:0];
            REG_CHANNEL_MODES:    modes_cfg = data[2*MASK_W-1:0];
            REG_ACTIVE_HIGH_MASK: polarity_cfg = data[MASK_W-1:0];
            REG_CRITICAL_ALLOWED: critical_ok_cfg = data[0];
            default: ;
        endcase
    endfunction

    function automatic void compute_channel_outputs(ctrl_item_t it);
        logic [TENTHS_W-1:0] pct;
        logic [MODE_W-1:0]   mode;
        logic [TENTHS_W-1:0] applied;
        logic [TIME_W-1:0]   cyc;
        logic [TIME_W-1:0]   elapsed;
        logic [TIME_W-1:0]   age;
        logic [TIME_W-1:0]   on_time;
        logic                lit;
        chan_result_t        res;
        if (it.kind == KIND_COMMAND)
        begin
            if (!enable_cfg[it.ch])
            begin
                return;
            end
            pct = (it.pct > FULL_TENTHS) ? FULL_TENTHS : it.pct;
            if (critical_cfg[it.ch] && !(critical_ok_cfg && !locked))
            begin
                pct = '0;
            end
            power_cmd[it.ch] = pct;
            stamp_ms[it.ch] = it.now;
            has_cmd[it.ch] = 1'b1;
            return;
        end
        locked = it.trip;
        for (int i = 0; i < NUM_CHANNELS; i++)
        begin
            if (it.trip)
            begin
                power_cmd[i] = '0;
            end
        end
        cyc = (window_len_cfg < CYCLE_MIN) ? CYCLE_MIN :
              (window_len_cfg > CYCLE_MAX) ? CYCLE_MAX : window_len_cfg;
        for (int i = 0; i < NUM_CHANNELS; i++)
        begin
            mode = modes_cfg[2*i +: 2];
            if (!enable_cfg[i])
            begin
                power_cmd[i] = '0;
            end
            else
            begin
                age = it.now - stamp_ms[i];
                if (power_cmd[i] != 0 && has_cmd[i] && it.now >= stamp_ms[i]
                        && age > timeout_cfg)
                begin
                    power_cmd[i] = '0;
                end
                if (critical_cfg[i] && !(critical_ok_cfg && !locked))
                begin
                    power_cmd[i] = '0;
                end
                if (locked)
                begin
                    power_cmd[i] = '0;
                end
            end
            applied = (power_cmd[i] > FULL_TENTHS) ? FULL_TENTHS : power_cmd[i];
            lit = 1'b0;
            if (applied != 0 && mode == MODE_ON_OFF)
            begin
                lit = (applied >= HALF_TENTHS);
            end
            else if (applied != 0 && mode == MODE_TIME_PROP)
            begin
                elapsed = it.now - window_ms[i];
                if (elapsed >= cyc)
                begin
                    window_ms[i] = it.now;
                end
                elapsed = it.now - window_ms[i];
                on_time = (cyc * applied) / FULL_TENTHS;
                lit = (applied >= FULL_TENTHS) || (elapsed < on_time);
            end
            res.ch = i;
            res.lit = lit;
            res.pin = (lit == polarity_cfg[i]);
            res.applied = applied;
            res.last = (i == NUM_CHANNELS - 1);
            expected_channel_results.push_back(res);
        end
    endfunction

    always @(posedge clk)
    begin : result_checker
        chan_result_t want;
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_channel_results.size() == 0)
                begin
                    report_mismatch("result with nothing pending", out_channel, 0,
                                    out_channel);
                end
                else
                begin
                    want = expected_channel_results.pop_front();
                    if (out_channel !== want.ch)
                        report_mismatch("out_channel", out_channel, want.ch, want.ch);
                    if (output_on !== want.lit)
                        report_mismatch("output_on", output_on, want.lit, want.ch);
                    if (pin_level !== want.pin)
                        report_mismatch("pin_level", pin_level, want.pin, want.ch);
                    if (applied_tenths !== want.applied)
                        report_mismatch("applied_tenths", applied_tenths, want.applied,
                                        want.ch);
                    if (last !== want.last)
                        report_mismatch("last", last, want.last, want.ch);
                end
            end
            if (item_valid && !item_stall)
            begin
                compute_channel_outputs('{kind, now_ms, channel, percent_tenths,
                                          safety_tripped});
            end
            if (cfg_valid && cfg_ready)
            begin
                apply_register(cfg_index, cfg_data);
            end
        end
    end

    always @(posedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            result_stall <= 1'b1;
        end
        else
        begin
            result_stall <= !steady && ($urandom_range(99) < IDLE_PERCENT);
        end
    end

    initial
    begin : watchdog
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((item_valid && !item_stall) || (result_valid && !result_stall)
                    || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic ctrl_item_t make_command(int unsigned ch, int unsigned pct,
                                                logic [TIME_W-1:0] now);
        ctrl_item_t it;
        it.kind = KIND_COMMAND;
        it.now = now;
        it.ch = ch;
        it.pct = pct;
        it.trip = 1'b0;
        return it;
    endfunction

    function automatic ctrl_item_t make_tick(logic [TIME_W-1:0] now, logic trip);
        ctrl_item_t it;
        it.kind = KIND_TICK;
        it.now = now;
        it.ch = '1;
        it.pct = '0;
        it.trip = trip;
        return it;
    endfunction

    // Most items follow a clock that moves forward in small steps, so windows,
    // timeouts and wraps are reached; the rest are arbitrary items.
    function automatic ctrl_item_t random_item();
        ctrl_item_t  it;
        int unsigned r;
        r = $urandom_range(99);
        it.ch = $urandom_range(7);
        it.trip = $urandom_range(1);
        if (r < 8)
        begin
            it.kind = $urandom_range(1);
            it.now = $urandom;
            it.pct = $urandom_range(1023);
            return it;
        end
        r = $urandom_range(99);
        if (r < 3)
            sim_ms += $urandom_range(20000);
        else if (r < 13)
            sim_ms += $urandom_range(3000);
        else
            sim_ms += $urandom_range(60);
        it.now = sim_ms;
        it.kind = ($urandom_range(99) < 40) ? KIND_COMMAND : KIND_TICK;
        if (it.kind == KIND_TICK)
            it.trip = ($urandom_range(99) < 6);
        r = $urandom_range(99);
        if (r < 15)
            it.pct = '0;
        else if (r < 30)
            it.pct = FULL_TENTHS;
        else if (r < 40)
            it.pct = $urandom_range(1023, 1001);
        else
            it.pct = $urandom_range(999, 1);
        return it;
    endfunction

    task automatic send_item(ctrl_item_t it);
        while (!steady && $urandom_range(99) < IDLE_PERCENT)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        kind <= it.kind;
        now_ms <= it.now;
        channel <= it.ch;
        percent_tenths <= it.pct;
        safety_tripped <= it.trip;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
    endtask

    task automatic wait_for_results();
        item_valid <= 1'b0;
        @(posedge clk);
        while (expected_channel_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(reg_index_t idx, logic [CFG_W-1:0] data);
        cfg_index <= idx;
        cfg_data <= data;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(logic [CFG_W-1:0] cycle, logic [CFG_W-1:0] timeout,
                             logic [MASK_W-1:0] enable, logic [MASK_W-1:0] critical,
                             logic [2*MASK_W-1:0] modes, logic [MASK_W-1:0] active_high,
                             logic allowed);
        wait_for_results();
        write_register(REG_CYCLE_MS, cycle);
        write_register(REG_TIMEOUT_MS, timeout);
        write_register(REG_ENABLE_MASK, enable);
        write_register(REG_CRITICAL_MASK, critical);
        write_register(REG_CHANNEL_MODES, modes);
        write_register(REG_ACTIVE_HIGH_MASK, active_high);
        write_register(REG_CRITICAL_ALLOWED, allowed);
    endtask

    task automatic run_random_items(int unsigned count);
        for (int unsigned n = 0; n < count; n++)
            send_item(random_item());
    endtask

    // With every channel disabled, commands are dropped and ticks report zero.
    task automatic test_after_reset();
        send_item(make_tick(32'd0, 1'b0));
        send_item(make_command(3, 1000, 32'd0));
        send_item(make_tick(32'd1, 1'b0));
    endtask

    task automatic test_directed_cases();
        configure(32'd1000, 32'd5000, 8'hFF, 8'h80,
                  {MODE_TIME_PROP, MODE_TIME_PROP, MODE_TIME_PROP, MODE_ON_OFF,
                   MODE_SPARE, MODE_TIME_PROP, MODE_ON_OFF, MODE_OFF},
                  8'h0F, 1'b0);
        send_item(make_command(1, 500, 32'd100));
        send_item(make_command(4, 499, 32'd100));
        send_item(make_command(2, 1000, 32'd100));
        send_item(make_command(5, 1023, 32'd100));
        send_item(make_command(6, 250, 32'd100));
        send_item(make_command(7, 800, 32'd100));
        send_item(make_command(0, 700, 32'd100));
        send_item(make_command(3, 700, 32'd100));
        send_item(make_tick(32'd100, 1'b0));
        send_item(make_tick(32'd300, 1'b0));
        send_item(make_tick(32'd1100, 1'b0));
        send_item(make_tick(32'd1349, 1'b0));
        send_item(make_command(1, 1, 32'd2000));
        send_item(make_tick(32'd2000, 1'b1));
        send_item(make_command(2, 600, 32'd2001));
        send_item(make_tick(32'd2002, 1'b0));
        send_item(make_tick(32'd7003, 1'b0));
        send_item(make_command(6, 900, 32'hFFFF_FFF0));
        send_item(make_tick(32'd5, 1'b0));
        send_item(make_tick(32'hFFFF_FFFF, 1'b0));
    endtask

    task automatic test_critical_lock();
        configure(32'd1000, 32'd5000, 8'hFF, 8'h80, {8{MODE_TIME_PROP}}, 8'hFF, 1'b1);
        send_item(make_command(7, 800, 32'd10));
        send_item(make_tick(32'd10, 1'b0));
        send_item(make_tick(32'd20, 1'b1));
        send_item(make_command(7, 800, 32'd21));
        send_item(make_tick(32'd22, 1'b0));
    endtask

    task automatic test_random_phases();
        configure(32'd200, 32'd0, 8'hFF, 8'h00, $urandom_range(65535),
                  $urandom_range(255), 1'b0);
        sim_ms = '0;
        run_random_items(64);
        configure(32'd10000, 32'hFFFF_FFFF, $urandom_range(255), $urandom_range(255),
                  {8{MODE_TIME_PROP}}, 8'h00, 1'b1);
        sim_ms = 32'hFFFF_F000;
        run_random_items(64);
        configure(32'd0, 32'd300, 8'hFF, 8'h0F, {8{MODE_TIME_PROP}}, 8'hFF, 1'b1);
        sim_ms = $urandom;
        run_random_items(64);
        configure(32'd16383, 32'd5000, $urandom_range(255), $urandom_range(255),
                  $urandom_range(65535), $urandom_range(255), 1'b0);
        run_random_items(64);
        configure(32'd10001, $urandom_range(4000), $urandom_range(255),
                  $urandom_range(255), $urandom_range(65535), $urandom_range(255),
                  1'b1);
        sim_ms = 32'hFFFF_FF00;
        run_random_items(64);
    endtask

    // The receiver holds off long enough for the block to stall its input.
    task automatic test_output_backpressure();
        configure(32'd500, 32'd2000, 8'hFF, 8'h00,
                  {{4{MODE_TIME_PROP}}, {4{MODE_ON_OFF}}}, 8'hAA, 1'b0);
        hold_request = HOLD_CYCLES;
        run_random_items(32);
        hold_request = HOLD_CYCLES;
        run_random_items(32);
    endtask

    task automatic test_steady_stream();
        configure(32'd199, 32'd1500, 8'hFF, 8'h81, $urandom_range(65535),
                  $urandom_range(255), 1'b1);
        steady = 1'b1;
        run_random_items(64);
        wait_for_results();
        steady = 1'b0;
        run_random_items(32);
    endtask

    initial
    begin
        for (int i = 0; i < NUM_CHANNELS; i++)
        begin
            power_cmd[i] = '0;
            stamp_ms[i] = '0;
            has_cmd[i] = 1'b0;
            window_ms[i] = '0;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_after_reset();
        test_directed_cases();
        test_critical_lock();
        test_random_phases();
        test_output_backpressure();
        test_steady_stream();
        wait_for_results();
        if (errors == 0 && expected_channel_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
